/* rtl/assert_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition in one cycle implies a property in the next
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/fbpa_pkg.sv */
// types, codes and constants of the block pool allocator
package fbpa_pkg;

  localparam int unsigned DEFAULT_MAX_BLOCKS = 1024;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned CAP_W      = 11;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CELL_W-1:0] BLOCK_SIZE_RESET = CELL_W'(8);

  // request operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;     // latch the request beat
    logic exec;       // perform the latched request and load the result
    logic load_mul;   // register effective capacity and region size
    logic load_pool;  // re-create the pool from the registers
  } fbpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cfg_hit;    // write to a defined register this cycle
    logic out_stall;  // result register holds a beat not yet taken
  } fbpa_sts_t;

endpackage

/* rtl/fbpa_ifs.sv */
// request and result channel interfaces
interface fbpa_req_if;
  import fbpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, operation, block_address, input ready);
  modport sink (input valid, operation, block_address, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;
  logic [CAP_W-1:0]    free_blocks;

  modport source (output valid, status, granted_address, free_blocks, input ready);
  modport sink (input valid, status, granted_address, free_blocks, output ready);
endinterface

/* rtl/fixed_block_pool_allocator_unit.sv */
// Fixed-size block pool allocator. Each request beat either allocates a block (oldest freed
// block first, else the next block carved downward from the top of the region) or frees one
// back to the queue; every request returns exactly one result beat with status, granted
// address and the free block count after the operation. In the idle state a request is latched
// and the head of the free queue memory read, whose read data is registered; in the exec state,
// which waits while an untaken result is held, the pointers are updated and the result register
// loaded, so no new request is taken until the last one has executed. The next request is taken
// while a result still waits in the output register. After reset and after every write to a
// defined register the pool is re-created (capacity times cell size is registered before the
// bump pointer is loaded), while no request is taken; blocks handed out earlier are forgotten.
module fixed_block_pool_allocator_unit #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fbpa_req_if.sink                        req,
  fbpa_rsp_if.source                      rsp
);
  import fbpa_pkg::*;

  fbpa_cmd_t cmd;
  fbpa_sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .req_operation       (req.operation),
    .req_block_address   (req.block_address),
    .rsp_ready           (rsp.ready),
    .rsp_valid           (rsp.valid),
    .rsp_status          (rsp.status),
    .rsp_granted_address (rsp.granted_address),
    .rsp_free_blocks     (rsp.free_blocks),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

/* rtl/fbpa_ctrl.sv */
// sequencing state machine of the block pool allocator
module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fbpa_pkg::fbpa_sts_t sts,
  output fbpa_pkg::fbpa_cmd_t cmd
);
  import fbpa_pkg::*;

  localparam logic [1:0] S_LOAD_MUL  = 2'd0;
  localparam logic [1:0] S_LOAD_POOL = 2'd1;
  localparam logic [1:0] S_IDLE      = 2'd2;
  localparam logic [1:0] S_EXEC      = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    priority if (sts.cfg_hit) begin
      state_next = S_LOAD_MUL;
    end else begin
      unique case (state)
        S_LOAD_MUL:  state_next = S_LOAD_POOL;
        S_LOAD_POOL: state_next = S_IDLE;
        S_IDLE:      if (req_valid) state_next = S_EXEC;
        S_EXEC:      if (!sts.out_stall) state_next = S_IDLE;
        default:     state_next = S_LOAD_MUL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD_MUL;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready     = (state == S_IDLE);
  assign cmd.accept    = (state == S_IDLE) && req_valid;
  assign cmd.exec      = (state == S_EXEC) && !sts.out_stall;
  assign cmd.load_mul  = (state == S_LOAD_MUL);
  assign cmd.load_pool = (state == S_LOAD_POOL);

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_to_exec, cmd.accept && !sts.cfg_hit, state == S_EXEC, "no exec after accept")
  `ASSERT_NEXT(a_cfg_rebuild, sts.cfg_hit, state == S_LOAD_MUL, "config write did not rebuild")
  `ASSERT_NEXT(a_mul_then_pool, cmd.load_mul && !sts.cfg_hit, cmd.load_pool, "rebuild sequence broken")

endmodule

/* rtl/fbpa_datapath.sv */
// registers, free queue memory and pointer arithmetic of the allocator
module fbpa_datapath #(
  parameter int unsigned MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                req_operation,
  input  logic [fbpa_pkg::ADDR_W-1:0]         req_block_address,
  input  logic                                rsp_ready,
  output logic                                rsp_valid,
  output logic [fbpa_pkg::STATUS_W-1:0]       rsp_status,
  output logic [fbpa_pkg::ADDR_W-1:0]         rsp_granted_address,
  output logic [fbpa_pkg::CAP_W-1:0]          rsp_free_blocks,
  input  fbpa_pkg::fbpa_cmd_t                 cmd,
  output fbpa_pkg::fbpa_sts_t                 sts
);
  import fbpa_pkg::*;

  localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned PROD_W = CNT_W + CELL_W;

  // configuration registers
  logic [ADDR_W-1:0] pool_base;
  logic [CELL_W-1:0] block_size;
  logic [CAP_W-1:0]  capacity_cells;

  // pool state
  logic [CNT_W-1:0]  cap_eff;
  logic [PROD_W-1:0] region_size;
  logic [IDX_W-1:0]  queue_head;
  logic [IDX_W-1:0]  queue_tail;
  logic [CNT_W-1:0]  queue_count;
  logic [CNT_W-1:0]  available_count;
  logic [ADDR_W-1:0] bump_pointer;

  // latched request
  logic              op_q;
  logic [ADDR_W-1:0] addr_q;

  logic [ADDR_W-1:0] free_queue [MAX_BLOCKS];
  logic [ADDR_W-1:0] head_data;

  logic [CNT_W-1:0]    cap_eff_next;
  logic [IDX_W-1:0]    queue_head_next;
  logic [IDX_W-1:0]    queue_tail_next;
  logic [CNT_W-1:0]    queue_count_next;
  logic [CNT_W-1:0]    available_count_next;
  logic [ADDR_W-1:0]   bump_pointer_next;
  logic [STATUS_W-1:0] status_next;
  logic [ADDR_W-1:0]   granted_next;
  logic                push;

  assign sts.cfg_hit = cfg_we && (cfg_index == REG_POOL_BASE ||
                                  cfg_index == REG_BLOCK_SIZE ||
                                  cfg_index == REG_CAPACITY);
  assign sts.out_stall = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base      <= '0;
      block_size     <= BLOCK_SIZE_RESET;
      capacity_cells <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE:  pool_base      <= cfg_wdata[ADDR_W-1:0];
        REG_BLOCK_SIZE: block_size     <= cfg_wdata[CELL_W-1:0];
        REG_CAPACITY:   capacity_cells <= cfg_wdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // capacity saturates at the queue depth
  always_comb begin
    if (32'(capacity_cells) > 32'(MAX_BLOCKS)) begin
      cap_eff_next = CNT_W'(MAX_BLOCKS);
    end else begin
      cap_eff_next = CNT_W'(capacity_cells);
    end
  end

  always_comb begin
    queue_head_next      = queue_head;
    queue_tail_next      = queue_tail;
    queue_count_next     = queue_count;
    available_count_next = available_count;
    bump_pointer_next    = bump_pointer;
    status_next          = ST_OK;
    granted_next         = '0;
    push                 = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (available_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          available_count_next = available_count - CNT_W'(1);
          if (queue_count != '0) begin
            granted_next     = head_data;
            queue_count_next = queue_count - CNT_W'(1);
            queue_head_next  = (queue_head == IDX_W'(MAX_BLOCKS - 1)) ? '0
                                                                      : queue_head + IDX_W'(1);
          end else begin
            // carve the next block downward from the untouched region
            bump_pointer_next = bump_pointer - ADDR_W'(block_size);
            granted_next      = bump_pointer_next;
          end
        end
      end
      OP_FREE: begin
        if (available_count >= cap_eff) begin
          status_next = ST_FULL;
        end else begin
          push                 = 1'b1;
          queue_count_next     = queue_count + CNT_W'(1);
          available_count_next = available_count + CNT_W'(1);
          queue_tail_next      = (queue_tail == IDX_W'(MAX_BLOCKS - 1)) ? '0
                                                                        : queue_tail + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_eff         <= '0;
      queue_head      <= '0;
      queue_tail      <= '0;
      queue_count     <= '0;
      available_count <= '0;
      bump_pointer    <= '0;
    end else if (cmd.load_mul) begin
      cap_eff <= cap_eff_next;
    end else if (cmd.load_pool) begin
      queue_head      <= '0;
      queue_tail      <= '0;
      queue_count     <= '0;
      available_count <= cap_eff;
      bump_pointer    <= pool_base + ADDR_W'(region_size);
    end else if (cmd.exec) begin
      queue_head      <= queue_head_next;
      queue_tail      <= queue_tail_next;
      queue_count     <= queue_count_next;
      available_count <= available_count_next;
      bump_pointer    <= bump_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      region_size <= PROD_W'(cap_eff_next) * PROD_W'(block_size);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= req_operation;
      addr_q <= req_block_address;
    end
  end

  // free queue: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.exec && push) begin
      free_queue[queue_tail] <= addr_q;
    end
    head_data <= free_queue[queue_head];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_status          <= status_next;
      rsp_granted_address <= granted_next;
      rsp_free_blocks     <= CAP_W'(available_count_next);
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_queue_within_avail, queue_count <= available_count, "queue exceeds free count")
  `ASSERT_ALWAYS(a_empty_queue_aligned, queue_count != '0 || queue_head == queue_tail, "empty queue misaligned")
  `ASSERT_NEXT(a_counts_hold, !cmd.exec && !cmd.load_pool, $stable(available_count) && $stable(queue_count), "counts moved without a command")

endmodule

/* test/fbpa_checker.sv */
// checker for the block pool allocator: watches config, request and result beats
`timescale 1ns / 1ps

module fbpa_checker import fbpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fbpa_req_if                   req,
  fbpa_rsp_if                   rsp,
  output int                    errors,
  output int                    pending,
  output int                    checked,
  output int                    empties,
  output int                    fulls,
  output int                    reissued
);

  localparam int unsigned POOL_MAX = DEFAULT_MAX_BLOCKS;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted;
    logic [CAP_W-1:0]    free_blocks;
  } alloc_result_t;

  // shadow of the pool registers and state
  logic [ADDR_W-1:0] base_r;
  logic [CELL_W-1:0] cell_r;
  logic [CAP_W-1:0]  cap_r;
  logic [ADDR_W-1:0] freed_fifo [POOL_MAX];
  int                fifo_rd, fifo_wr, fifo_cnt;
  logic [ADDR_W-1:0] carve_ptr;
  logic [CAP_W-1:0]  avail_cnt;

  alloc_result_t expected_q [$];
  int err_cnt, check_cnt, empty_cnt, full_cnt, reissue_cnt;

  function automatic logic [CAP_W-1:0] usable_blocks();
    return (cap_r > CAP_W'(POOL_MAX)) ? CAP_W'(POOL_MAX) : cap_r;
  endfunction

  function automatic void rebuild_pool();
    fifo_rd   = 0;
    fifo_wr   = 0;
    fifo_cnt  = 0;
    carve_ptr = base_r + ADDR_W'(usable_blocks()) * ADDR_W'(cell_r);
    avail_cnt = usable_blocks();
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_POOL_BASE: begin
        base_r = data[ADDR_W-1:0];
        rebuild_pool();
      end
      REG_BLOCK_SIZE: begin
        cell_r = data[CELL_W-1:0];
        rebuild_pool();
      end
      REG_CAPACITY: begin
        cap_r = data[CAP_W-1:0];
        rebuild_pool();
      end
      default: ;
    endcase
  endfunction

  function automatic alloc_result_t predict_request(input logic op,
                                                    input logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    r = '0;
    if (op == OP_ALLOC) begin
      if (avail_cnt == 0) begin
        r.status = ST_EMPTY;
        empty_cnt++;
      end else begin
        avail_cnt--;
        if (fifo_cnt > 0) begin
          // oldest freed block goes out first
          r.granted = freed_fifo[fifo_rd];
          fifo_rd   = (fifo_rd == POOL_MAX - 1) ? 0 : fifo_rd + 1;
          fifo_cnt--;
          reissue_cnt++;
        end else begin
          carve_ptr = carve_ptr - ADDR_W'(cell_r);
          r.granted = carve_ptr;
        end
      end
    end else begin
      if (avail_cnt >= usable_blocks()) begin
        r.status = ST_FULL;
        full_cnt++;
      end else begin
        freed_fifo[fifo_wr] = addr;
        fifo_wr = (fifo_wr == POOL_MAX - 1) ? 0 : fifo_wr + 1;
        fifo_cnt++;
        avail_cnt++;
      end
    end
    r.free_blocks = avail_cnt;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [ADDR_W-1:0] exp_v,
                            input logic [ADDR_W-1:0] act_v);
    $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, act_v);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      base_r = '0;
      cell_r = BLOCK_SIZE_RESET;
      cap_r  = '0;
      rebuild_pool();
      expected_q.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (req.valid && req.ready)
        expected_q.push_back(predict_request(req.operation, req.block_address));
      if (rsp.valid && rsp.ready) begin
        check_cnt++;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected (status %0h, address %0h)",
                   $time, rsp.status, rsp.granted_address);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.status !== want.status)
            flag_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
          if (rsp.granted_address !== want.granted)
            flag_field("granted_address", want.granted, rsp.granted_address);
          if (rsp.free_blocks !== want.free_blocks)
            flag_field("free_blocks", ADDR_W'(want.free_blocks), ADDR_W'(rsp.free_blocks));
        end
      end
    end
    errors   <= err_cnt;
    pending  <= expected_q.size();
    checked  <= check_cnt;
    empties  <= empty_cnt;
    fulls    <= full_cnt;
    reissued <= reissue_cnt;
  end

endmodule

/* test/testbench.sv */
// top of the allocator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
  import fbpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  int errors, pending, checked, empties, fulls, reissued;

  // receiver control
  int       rx_mode;
  bit       hold_req;
  logic [7:0] rx_pattern;
  logic [2:0] rx_tick;

  // sender state and the pool as last programmed
  bit                gaps_on;
  int                burst_left;
  int                settings_used;
  logic [ADDR_W-1:0] cur_base;
  logic [CELL_W-1:0] cur_cell;
  logic [CAP_W-1:0]  cur_cap;

  fixed_block_pool_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  fbpa_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .empties   (empties),
    .fulls     (fulls),
    .reissued  (reissued)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: stall pattern per phase, plus an occasional long hold-off
  initial begin
    int held;
    rsp_ch.ready <= 1'b0;
    rx_tick = '0;
    forever begin
      @(posedge clk);
      rx_tick = rx_tick + 3'd1;
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      case (rx_mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(99) < 75);
        2:       rsp_ch.ready <= rx_pattern[rx_tick];
        default: rsp_ch.ready <= ($urandom_range(99) < 30);
      endcase
    end
  end

  task automatic send_req(input logic op, input logic [ADDR_W-1:0] addr);
    req_ch.valid         <= 1'b1;
    req_ch.operation     <= op;
    req_ch.block_address <= addr;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic pause_sender(input int n);
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= 1'($urandom());
    req_ch.block_address <= $urandom();
    repeat (n) @(posedge clk);
  endtask

  task automatic offer(input logic op, input logic [ADDR_W-1:0] addr);
    send_req(op, addr);
    if (gaps_on) begin
      if (burst_left == 0) begin
        pause_sender($urandom_range(1, 6));
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop offering until every result beat is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic write_pool(input logic [ADDR_W-1:0] base, input logic [CELL_W-1:0] blk_bytes,
                            input logic [CAP_W-1:0] cap);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_BLOCK_SIZE, {16'($urandom()), blk_bytes});
    write_reg(REG_CAPACITY, {21'($urandom()), cap});
    cfg_we   <= 1'b0;
    cur_base = base;
    cur_cell = blk_bytes;
    cur_cap  = cap;
    settings_used++;
  endtask

  // mostly addresses of blocks inside the pool, sometimes anything
  function automatic logic [ADDR_W-1:0] pool_addr();
    int k;
    k = (cur_cap == 0) ? 0 : $urandom_range(int'(cur_cap) - 1);
    if ($urandom_range(3) == 0) return $urandom();
    return cur_base + ADDR_W'(k) * ADDR_W'(cur_cell);
  endfunction

  initial begin
    logic [CAP_W-1:0] cap;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.operation     <= OP_ALLOC;
    req_ch.block_address <= '0;
    rx_mode       = 0;
    rx_pattern    = 8'hFF;
    hold_req      = 1'b0;
    gaps_on       = 1'b0;
    burst_left    = 0;
    settings_used = 1;
    cur_base      = '0;
    cur_cell      = BLOCK_SIZE_RESET;
    cur_cap       = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // empty pool out of reset: both requests refused
    send_req(OP_ALLOC, 32'h0);
    send_req(OP_FREE, 32'hFFFF_FFFF);
    drain();

    // carving wraps below address zero, then free queue order
    write_pool(32'hFFFF_FFF0, 16'd16, 11'd3);
    repeat (4) send_req(OP_ALLOC, $urandom());
    send_req(OP_FREE, 32'hFFFF_FFFF);
    send_req(OP_FREE, 32'h0);
    send_req(OP_FREE, 32'h1234_5678);
    send_req(OP_FREE, 32'hAAAA_5555);
    repeat (3) send_req(OP_ALLOC, $urandom());
    drain();

    // oversize capacity saturates, zero cell size hands out the base
    write_pool(32'hFFFF_FFFF, 16'd0, 11'd2047);
    repeat (2) send_req(OP_ALLOC, $urandom());
    drain();

    // widest cells; a write to the unused index leaves the pool alone
    write_pool(32'h0, 16'hFFFF, 11'd1024);
    send_req(OP_ALLOC, $urandom());
    drain();
    write_reg(REG_UNUSED, $urandom());
    cfg_we <= 1'b0;
    send_req(OP_ALLOC, $urandom());
    send_req(OP_FREE, 32'h5555_AAAA);
    send_req(OP_ALLOC, $urandom());
    drain();

    // odd cell size, single block
    write_pool(32'h8000_0000, 16'd5, 11'd1);
    send_req(OP_ALLOC, $urandom());
    send_req(OP_ALLOC, $urandom());
    send_req(OP_FREE, 32'h8000_0000);
    drain();

    for (int p = 0; p < 13; p++) begin
      int n_items;
      int bias;
      logic op;
      case (p % 6)
        0: write_pool($urandom(), 16'($urandom_range(8, 64)), 11'($urandom_range(1, 12)));
        1: write_pool($urandom(), 16'($urandom()), 11'd0);
        2: write_pool($urandom(), 16'hFFFF, 11'($urandom_range(1024, 2047)));
        3: write_pool($urandom(), 16'($urandom_range(0, 7)), 11'($urandom_range(1, 4)));
        4: write_pool($urandom(), 16'($urandom()), 11'($urandom_range(1, 64)));
        default: begin
          // capacity only, base and cell size stay
          cap = 11'($urandom());
          write_reg(REG_CAPACITY, {21'($urandom()), cap});
          cfg_we <= 1'b0;
          cur_cap = cap;
          settings_used++;
        end
      endcase
      rx_mode    = p % 4;
      rx_pattern = 8'($urandom_range(1, 255));
      gaps_on    = (p % 3 != 0);
      burst_left = $urandom_range(1, 20);
      n_items    = (cur_cap == 0) ? 30 : $urandom_range(80, 130);
      for (int i = 0; i < n_items; i++) begin
        // lean toward allocation first, then toward freeing
        bias = (i < n_items / 2) ? 70 : 30;
        op   = ($urandom_range(99) < bias) ? OP_ALLOC : OP_FREE;
        if ((p == 2 || p == 8) && i == 10) hold_req = 1'b1;
        if (p == 5 && i == n_items / 2) drain();
        offer(op, (op == OP_FREE) ? pool_addr() : ADDR_W'($urandom()));
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("checked %0d result beats across %0d pool settings", checked, settings_used);
    $display("%0d blocks reissued from the free queue, %0d empty and %0d full refusals",
             reissued, empties, fulls);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
